>>> hdl/ypcv_pkg.sv
// ----------------------------------------------------------------------------
// ypcv_pkg
// Shared types and constants of the yaw/pitch camera vector unit: CORDIC
// word widths, arctangent table, gain and configuration register indexes.
// ----------------------------------------------------------------------------
package ypcv_pkg;

    // Product of mouse delta, sensitivity and frame time (signed 16 x 10 x 16)
    localparam int PROD_W = 42;

    // CORDIC angle: signed degrees with 24 fraction bits
    localparam int ANG_FRAC = 24;
    localparam int ANG_W    = 35;
    // CORDIC vector: signed Q30
    localparam int XY_W     = 32;

    localparam int ATAN_LEN   = 24;
    localparam int ATAN_IDX_W = 5;

    localparam logic signed [XY_W-1:0] GAIN_Q30 = 32'sd652032874;

    localparam logic signed [ANG_W-1:0] HALF_TURN    = 35'sd180 <<< ANG_FRAC;
    localparam logic signed [ANG_W-1:0] FULL_TURN    = 35'sd360 <<< ANG_FRAC;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 35'sd90 <<< ANG_FRAC;

    // Pitch limit never goes beyond this many degrees
    localparam logic [6:0] PITCH_CAP = 7'd89;

    // Yaw reduction: 360 degrees is 45 * 2^(frac+3); the part of the delta
    // above those low bits is under 2^22 and is reduced modulo 45 with
    // floor(n * MOD_RECIP / 2^MOD_RECIP_SH), exact for every n below 2^22
    localparam int MOD_N_W      = 22;
    localparam int MOD_Q_W      = 17;
    localparam int MOD_RECIP_SH = 28;
    localparam logic [22:0] MOD_RECIP = 23'd5965233;
    localparam logic [5:0]  MOD_DIV   = 6'd45;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PITCH   = 2'd1;

    localparam logic [9:0] SENS_RESET  = 10'd100;
    localparam logic [6:0] MAXP_RESET  = 7'd89;

    // Request to the CORDIC unit
    typedef struct packed {
        logic                    start;
        logic signed [ANG_W-1:0] angle;
    } cordic_req_t;

    // Result from the CORDIC unit
    typedef struct packed {
        logic                   done;
        logic signed [XY_W-1:0] cos_val;
        logic signed [XY_W-1:0] sin_val;
    } cordic_rsp_t;

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic signed [ANG_W-1:0] atan_deg(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 35'sd754974720;
            5'd1:    v = 35'sd445687602;
            5'd2:    v = 35'sd235489088;
            5'd3:    v = 35'sd119537938;
            5'd4:    v = 35'sd60000934;
            5'd5:    v = 35'sd30029717;
            5'd6:    v = 35'sd15018523;
            5'd7:    v = 35'sd7509720;
            5'd8:    v = 35'sd3754917;
            5'd9:    v = 35'sd1877466;
            5'd10:   v = 35'sd938734;
            5'd11:   v = 35'sd469367;
            5'd12:   v = 35'sd234684;
            5'd13:   v = 35'sd117342;
            5'd14:   v = 35'sd58671;
            5'd15:   v = 35'sd29335;
            5'd16:   v = 35'sd14668;
            5'd17:   v = 35'sd7334;
            5'd18:   v = 35'sd3667;
            5'd19:   v = 35'sd1833;
            5'd20:   v = 35'sd917;
            5'd21:   v = 35'sd458;
            5'd22:   v = 35'sd229;
            5'd23:   v = 35'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/ypcv_cordic.sv
// ----------------------------------------------------------------------------
// ypcv_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, returns
// cosine and sine of an angle in degrees (Q24) as Q30 values.
// ----------------------------------------------------------------------------
module ypcv_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ypcv_pkg::cordic_req_t req,
    output ypcv_pkg::cordic_rsp_t rsp
);
    import ypcv_pkg::*;

    localparam int STEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int IW    = $clog2(STEPS);
    localparam logic [IW-1:0] LAST = IW'(STEPS - 1);

    logic signed [XY_W-1:0]  x_reg, y_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic [IW-1:0]           i_reg;
    logic                    flip_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic signed [ANG_W-1:0] z_wrap, z_fold, at;
    logic                    fold;
    logic signed [XY_W-1:0]  xs, ys;

    // Range reduction: wrap to +/-180, then fold into +/-90 with a sign flip
    always_comb begin
        if (req.angle > HALF_TURN) begin
            z_wrap = req.angle - FULL_TURN;
        end else if (req.angle < -HALF_TURN) begin
            z_wrap = req.angle + FULL_TURN;
        end else begin
            z_wrap = req.angle;
        end
        fold = 1'b1;
        if (z_wrap > QUARTER_TURN) begin
            z_fold = z_wrap - HALF_TURN;
        end else if (z_wrap < -QUARTER_TURN) begin
            z_fold = z_wrap + HALF_TURN;
        end else begin
            z_fold = z_wrap;
            fold   = 1'b0;
        end
    end

    // Shared micro-rotation terms
    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign at = atan_deg(ATAN_IDX_W'(i_reg));

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && i_reg == LAST) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            x_reg    <= GAIN_Q30;
            y_reg    <= '0;
            z_reg    <= z_fold;
            flip_reg <= fold;
            i_reg    <= '0;
        end else if (busy_reg) begin
            if (z_reg >= 0) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
            i_reg <= i_reg + 1'b1;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.cos_val = flip_reg ? -x_reg : x_reg;
    assign rsp.sin_val = flip_reg ? -y_reg : y_reg;

endmodule

>>> hdl/yaw_pitch_camera_vector_unit.sv
// ----------------------------------------------------------------------------
// yaw_pitch_camera_vector_unit
// Mouse-look camera: updates yaw/pitch from mouse deltas and returns the view
// direction and the horizontal move vector.
// ----------------------------------------------------------------------------
// s_ready is low from the acceptance of an item until the sequencer returns to
// idle. The work is done by one shared 32x32 multiplier
// (four products for the angle deltas, two for the reduction of the yaw delta
// modulo 360 degrees by reciprocal multiplication, two for the direction) and
// one iterative CORDIC that runs STEPS rotations (CORDIC_STEPS, at most 24) for
// yaw and then again for pitch. A finished item sits in the
// output register, so the next item is accepted while it waits.
// Configuration writes are taken in any cycle.
module yaw_pitch_camera_vector_unit #(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int VEC_FRAC_BITS   = 14,
    parameter int CORDIC_STEPS    = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ypcv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ypcv_pkg::CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [15:0]              s_mouse_dx,
    input  logic signed [15:0]              s_mouse_dy,
    input  logic [15:0]                     s_frame_time,
    input  logic                            s_key_forward,
    input  logic                            s_key_back,
    input  logic                            s_key_left,
    input  logic                            s_key_right,
    // result items
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [15:0]              m_dir_x,
    output logic signed [15:0]              m_dir_y,
    output logic signed [15:0]              m_dir_z,
    output logic signed [15:0]              m_move_x,
    output logic signed [15:0]              m_move_z
);
    import ypcv_pkg::*;

    localparam int AFB       = ANGLE_FRAC_BITS;
    localparam int SH_L      = (AFB >= 16) ? AFB - 16 : 0;
    localparam int SH_R      = (AFB < 16) ? 16 - AFB : 0;
    localparam int SCL_W     = PROD_W + SH_L;
    localparam int MAG_W     = SCL_W + 1;
    localparam int DW        = SCL_W + 2;
    localparam int YAW_W     = AFB + 9;
    localparam int PITCH_W   = AFB + 8;
    localparam int LOW_B     = AFB + 3;
    localparam int Q24_SH    = ANG_FRAC - AFB;
    localparam int OUT_W     = 36;
    localparam int OUT_SH    = 30 - VEC_FRAC_BITS;

    localparam logic [YAW_W-1:0] FULL_ANG = YAW_W'(360) << AFB;
    localparam logic [MAG_W-1:0] LOW_MASK = (MAG_W'(1) << LOW_B) - MAG_W'(1);
    localparam logic signed [63:0]     RND_Q30  = 64'sd1 <<< 29;
    localparam logic signed [OUT_W-1:0] OUT_HALF = 36'sd1 <<< (OUT_SH - 1);
    localparam logic signed [OUT_W-1:0] SAT_HI   = 36'sd32767;
    localparam logic signed [OUT_W-1:0] SAT_LO   = -36'sd32768;

    typedef enum logic [4:0] {
        S_IDLE, S_MX1, S_MX2, S_MY1, S_MY2, S_PITCH, S_MQ, S_MR, S_MREM, S_YAW,
        S_CYAW, S_WYAW, S_CPIT, S_WPIT, S_P1, S_P2, S_P3, S_DONE
    } state_t;

    state_t state_reg;

    // Configuration and angle state
    logic [9:0]               sens_reg;
    logic [6:0]               maxp_reg;
    logic [YAW_W-1:0]         yaw_reg, yaw_next;
    logic signed [PITCH_W-1:0] pitch_reg, pitch_next;
    logic                     m_valid_reg, m_valid_next;

    // Item payload
    logic signed [15:0] dx_reg, dy_reg;
    logic [15:0]        ft_reg;
    logic               kf_reg, kb_reg, kl_reg, kr_reg;

    // Shared multiplier
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_reg;

    // Modulo unit
    logic [MAG_W-1:0]   rem_reg, rem_next, mag;
    logic               neg_reg;
    logic [MOD_N_W-1:0] n_val, r_low;
    logic [MOD_Q_W-1:0] q_val;

    // CORDIC results
    logic signed [XY_W-1:0] cy_reg, sy_reg, cp_reg, sp_reg;

    // Result holding
    logic signed [15:0] res_dx_reg, res_dy_reg, res_dz_reg, res_mx_reg, res_mz_reg;
    logic signed [15:0] m_dx_reg, m_dy_reg, m_dz_reg, m_mx_reg, m_mz_reg;

    cordic_req_t creq;
    cordic_rsp_t crsp;

    // Round to VEC_FRAC_BITS (ties up) and saturate to 16 bits
    function automatic logic signed [15:0] to_out(input logic signed [OUT_W-1:0] q);
        logic signed [OUT_W-1:0] r;
        r = (q + OUT_HALF) >>> OUT_SH;
        if (r > SAT_HI) begin
            r = SAT_HI;
        end else if (r < SAT_LO) begin
            r = SAT_LO;
        end
        return r[15:0];
    endfunction

    // Multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MX1: begin
                mul_a = 32'(dx_reg);
                mul_b = $signed(32'(sens_reg));
            end
            S_MX2, S_MY2: begin
                mul_a = mul_reg[31:0];
                mul_b = $signed(32'(ft_reg));
            end
            S_MY1: begin
                mul_a = 32'(dy_reg);
                mul_b = $signed(32'(sens_reg));
            end
            S_MQ: begin
                mul_a = $signed(32'(n_val));
                mul_b = $signed(32'(MOD_RECIP));
            end
            S_MR: begin
                mul_a = $signed(32'(q_val));
                mul_b = $signed(32'(MOD_DIV));
            end
            S_P1: begin
                mul_a = cy_reg;
                mul_b = cp_reg;
            end
            S_P2: begin
                mul_a = sy_reg;
                mul_b = cp_reg;
            end
            default: ;
        endcase
    end

    // Scale the raw product to angle fraction bits
    logic signed [SCL_W-1:0] sc_ext, sc;
    logic signed [MAG_W-1:0] sc_w;
    assign sc_ext = SCL_W'($signed(mul_reg[PROD_W-1:0]));
    assign sc     = (sc_ext <<< SH_L) >>> SH_R;
    assign sc_w   = MAG_W'(sc);
    assign mag    = (sc < 0) ? MAG_W'(-sc_w) : MAG_W'(sc_w);

    // Pitch update with clamp
    logic [6:0]           mp;
    logic signed [DW-1:0] diff, lim;
    always_comb begin
        mp   = (maxp_reg > PITCH_CAP) ? PITCH_CAP : maxp_reg;
        lim  = $signed(DW'(mp)) <<< AFB;
        diff = DW'(pitch_reg) - DW'(sc);
        if (diff > lim) begin
            diff = lim;
        end else if (diff < -lim) begin
            diff = -lim;
        end
        pitch_next = PITCH_W'(diff);
    end

    // Remainder modulo 360 degrees: low bits pass, upper part modulo 45
    always_comb begin
        n_val    = rem_reg[LOW_B +: MOD_N_W];
        q_val    = mul_reg[MOD_RECIP_SH +: MOD_Q_W];
        r_low    = n_val - mul_reg[MOD_N_W-1:0];
        rem_next = (MAG_W'(r_low) << LOW_B) | (rem_reg & LOW_MASK);
    end

    // Yaw update modulo 360 degrees
    logic [YAW_W-1:0] rm, radd;
    logic [YAW_W:0]   ysum;
    always_comb begin
        rm   = YAW_W'(rem_reg);
        radd = (neg_reg && rm != '0) ? FULL_ANG - rm : rm;
        ysum = {1'b0, yaw_reg} + {1'b0, radd};
        if (ysum >= {1'b0, FULL_ANG}) begin
            ysum = ysum - {1'b0, FULL_ANG};
        end
        yaw_next = ysum[YAW_W-1:0];
    end

    // CORDIC request
    assign creq.start = (state_reg == S_CYAW) || (state_reg == S_CPIT);
    assign creq.angle = (state_reg == S_CYAW) ? ($signed(ANG_W'(yaw_reg)) <<< Q24_SH)
                                              : (ANG_W'(pitch_reg) <<< Q24_SH);

    ypcv_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (creq),
        .rsp     (crsp)
    );

    // Output formation
    logic signed [63:0]      prod_rnd;
    logic signed [OUT_W-1:0] prod_q, cy_w, sy_w, cp_w, sp_w, fcy, fsy, scy, ssy;
    logic                    f_pos, f_neg, s_pos, s_neg;
    always_comb begin
        prod_rnd = (mul_reg + RND_Q30) >>> 30;
        prod_q   = OUT_W'(prod_rnd);
        cy_w     = OUT_W'(cy_reg);
        sy_w     = OUT_W'(sy_reg);
        cp_w     = OUT_W'(cp_reg);
        sp_w     = OUT_W'(sp_reg);
        f_pos    = kf_reg & ~kb_reg;
        f_neg    = kb_reg & ~kf_reg;
        s_pos    = kr_reg & ~kl_reg;
        s_neg    = kl_reg & ~kr_reg;
        fcy      = f_pos ? cy_w : (f_neg ? -cy_w : '0);
        fsy      = f_pos ? sy_w : (f_neg ? -sy_w : '0);
        scy      = s_pos ? cy_w : (s_neg ? -cy_w : '0);
        ssy      = s_pos ? sy_w : (s_neg ? -sy_w : '0);
    end

    // Result valid: cleared on acceptance, set when a finished item moves out
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_valid_next = 1'b1;
        end
    end

    // Sequencer, configuration and angle state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            sens_reg    <= SENS_RESET;
            maxp_reg    <= MAXP_RESET;
            yaw_reg     <= '0;
            pitch_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_SENSITIVITY: sens_reg <= cfg_data[9:0];
                    CFG_MAX_PITCH:   maxp_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
            m_valid_reg <= m_valid_next;
            unique case (state_reg)
                S_IDLE:  if (s_valid) state_reg <= S_MX1;
                S_MX1:   state_reg <= S_MX2;
                S_MX2:   state_reg <= S_MY1;
                S_MY1:   state_reg <= S_MY2;
                S_MY2:   state_reg <= S_PITCH;
                S_PITCH: begin
                    pitch_reg <= pitch_next;
                    state_reg <= S_MQ;
                end
                S_MQ:    state_reg <= S_MR;
                S_MR:    state_reg <= S_MREM;
                S_MREM:  state_reg <= S_YAW;
                S_YAW: begin
                    yaw_reg   <= yaw_next;
                    state_reg <= S_CYAW;
                end
                S_CYAW:  state_reg <= S_WYAW;
                S_WYAW:  if (crsp.done) state_reg <= S_CPIT;
                S_CPIT:  state_reg <= S_WPIT;
                S_WPIT:  if (crsp.done) state_reg <= S_P1;
                S_P1:    state_reg <= S_P2;
                S_P2:    state_reg <= S_P3;
                S_P3:    state_reg <= S_DONE;
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    dx_reg <= s_mouse_dx;
                    dy_reg <= s_mouse_dy;
                    ft_reg <= s_frame_time;
                    kf_reg <= s_key_forward;
                    kb_reg <= s_key_back;
                    kl_reg <= s_key_left;
                    kr_reg <= s_key_right;
                end
            end
            S_MX1, S_MX2, S_MY2, S_MQ, S_MR, S_P1: mul_reg <= mul_a * mul_b;
            S_MY1: begin
                mul_reg <= mul_a * mul_b;
                rem_reg <= mag;
                neg_reg <= sc < 0;
            end
            S_MREM: begin
                rem_reg <= rem_next;
            end
            S_WYAW: begin
                if (crsp.done) begin
                    cy_reg <= crsp.cos_val;
                    sy_reg <= crsp.sin_val;
                end
            end
            S_WPIT: begin
                if (crsp.done) begin
                    cp_reg <= crsp.cos_val;
                    sp_reg <= crsp.sin_val;
                end
            end
            S_P2: begin
                mul_reg    <= mul_a * mul_b;
                res_dx_reg <= to_out(prod_q);
            end
            S_P3: begin
                res_dz_reg <= to_out(prod_q);
                res_dy_reg <= to_out(sp_w);
                res_mx_reg <= to_out(fcy - ssy);
                res_mz_reg <= to_out(fsy + scy);
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_dx_reg <= res_dx_reg;
                    m_dy_reg <= res_dy_reg;
                    m_dz_reg <= res_dz_reg;
                    m_mx_reg <= res_mx_reg;
                    m_mz_reg <= res_mz_reg;
                end
            end
            default: ;
        endcase
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_dir_x   = m_dx_reg;
    assign m_dir_y   = m_dy_reg;
    assign m_dir_z   = m_dz_reg;
    assign m_move_x  = m_mx_reg;
    assign m_move_z  = m_mz_reg;

endmodule

>>> hdl/ypcv_checker.sv
// ----------------------------------------------------------------------------
// ypcv_checker
// Port-level checks of the camera vector unit, bound to the top level.
// ----------------------------------------------------------------------------
module ypcv_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_dir_x,
    input logic signed [15:0] m_dir_y
);

    // A waiting result item stays offered
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped while stalled");

    // A waiting result item keeps its payload
    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_dir_x) && $stable(m_dir_y))
        else $error("result payload changed while stalled");

    // An accepted item keeps the unit busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("input taken while an item is in work");

    // Reset leaves no result pending and the input open
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("state after reset wrong");

endmodule

bind yaw_pitch_camera_vector_unit ypcv_checker u_ypcv_checker (.*);

>>> tb/yaw_pitch_camera_vector_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yaw_pitch_camera_vector_unit_tb
// Self-checking bench for the camera vector unit. A queue of frame items feeds
// a valid/ready driver with random gaps. Each accepted item updates a local
// copy of the yaw/pitch state, and the expected direction and move vectors
// are queued. A monitor with random stalls compares every result field by
// field. Several sensitivity / pitch-limit settings are visited, extremes too.
// ----------------------------------------------------------------------------
module yaw_pitch_camera_vector_unit_tb;
    import ypcv_pkg::*;

    typedef struct {
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [15:0]        ft;
        logic               kf, kb, kl, kr;
    } frame_in_t;

    typedef struct {
        logic signed [15:0] dir_x, dir_y, dir_z, move_x, move_z;
    } cam_vec_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_mouse_dx = '0, s_mouse_dy = '0;
    logic [15:0] s_frame_time = '0;
    logic s_key_forward = 1'b0, s_key_back = 1'b0, s_key_left = 1'b0, s_key_right = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_dir_x, m_dir_y, m_dir_z, m_move_x, m_move_z;

    yaw_pitch_camera_vector_unit dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Local copy of block state and registers
    longint yaw_deg, pitch_deg;
    int unsigned sens_reg, maxp_reg;
    longint atan_q24 [16] = '{754974720, 445687602, 235489088, 119537938, 60000934,
        30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335};

    frame_in_t pending_frames[$];
    cam_vec_t  expected_vecs[$];
    int n_errors = 0;
    int n_results = 0;
    int n_accepted = 0;

    // Rotation-mode CORDIC on an angle with 16 fraction bits, Q30 out
    task automatic cordic_sincos(input longint a, output longint c, output longint s);
        longint z, x, y, nx, half_t, quart_t;
        bit flip;
        half_t = 64'sd180 <<< 24;
        quart_t = 64'sd90 <<< 24;
        z = a <<< 8;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > half_t) z -= 2 * half_t;
        if (z < -half_t) z += 2 * half_t;
        if (z > quart_t) begin
            z -= half_t; flip = 1;
        end else if (z < -quart_t) begin
            z += half_t; flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_q24[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_q24[i];
            end
            x = nx;
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = x;
        s = y;
    endtask

    // Q30 to Q1.14, round half up, saturate
    function automatic logic signed [15:0] q30_to_vec(input longint q);
        longint r;
        r = (q + 64'sd32768) >>> 16;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    // Advance the camera angles by one frame and form the expected vectors
    task automatic camera_step(input frame_in_t f, output cam_vec_t v);
        longint full_t, lim, r, cy, sy, cp, sp, fwd, side;
        int unsigned mp;
        full_t = 64'sd360 <<< 16;
        mp = (maxp_reg > 89) ? 89 : maxp_reg;
        lim = longint'(mp) <<< 16;
        fwd = longint'(f.kf) - longint'(f.kb);
        side = longint'(f.kr) - longint'(f.kl);
        r = (longint'(f.dx) * longint'(sens_reg) * longint'(f.ft)) % full_t;
        if (r < 0) r += full_t;
        yaw_deg = (yaw_deg + r) % full_t;
        pitch_deg -= longint'(f.dy) * longint'(sens_reg) * longint'(f.ft);
        if (pitch_deg > lim) pitch_deg = lim;
        if (pitch_deg < -lim) pitch_deg = -lim;
        cordic_sincos(yaw_deg, cy, sy);
        cordic_sincos(pitch_deg, cp, sp);
        v.dir_x = q30_to_vec((cy * cp + (64'sd1 <<< 29)) >>> 30);
        v.dir_y = q30_to_vec(sp);
        v.dir_z = q30_to_vec((sy * cp + (64'sd1 <<< 29)) >>> 30);
        v.move_x = q30_to_vec(fwd * cy - side * sy);
        v.move_z = q30_to_vec(fwd * sy + side * cy);
    endtask

    // Mostly short gaps, a few long ones, and whole stretches without any
    function automatic int pick_gap(input bit busy_mode);
        int p;
        if (busy_mode) return 0;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 94) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    bit s_burst = 0, m_burst = 0;

    // Driver: one item per handshake, valid held until accepted
    int s_gap = 0;
    always @(posedge aclk) begin
        frame_in_t f;
        cam_vec_t v;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                f.dx = s_mouse_dx; f.dy = s_mouse_dy; f.ft = s_frame_time;
                f.kf = s_key_forward; f.kb = s_key_back;
                f.kl = s_key_left; f.kr = s_key_right;
                camera_step(f, v);
                expected_vecs.push_back(v);
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if ($urandom_range(0, 199) == 0) s_burst = !s_burst;
                if (s_gap > 0) begin
                    s_gap--;
                    s_valid <= 1'b0;
                end else if (pending_frames.size() > 0) begin
                    f = pending_frames.pop_front();
                    s_mouse_dx <= f.dx; s_mouse_dy <= f.dy; s_frame_time <= f.ft;
                    s_key_forward <= f.kf; s_key_back <= f.kb;
                    s_key_left <= f.kl; s_key_right <= f.kr;
                    s_valid <= 1'b1;
                    s_gap = pick_gap(s_burst);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted on its own
    int hold_cnt = 0;
    bit hold_go = 0, hold_done = 0;
    always @(posedge aclk) begin
        if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
        else if (hold_go && !hold_done) begin
            hold_cnt <= 3000;
            hold_done <= 1'b1;
        end
    end

    // Monitor: compare each result item with the oldest expectation
    int m_gap = 0;
    always @(posedge aclk) begin
        cam_vec_t e;
        bit bad;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_results++;
                if (expected_vecs.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) $display("unexpected result item at %0t", $realtime);
                end else begin
                    e = expected_vecs.pop_front();
                    bad = (m_dir_x !== e.dir_x) || (m_dir_y !== e.dir_y) ||
                          (m_dir_z !== e.dir_z) || (m_move_x !== e.move_x) ||
                          (m_move_z !== e.move_z);
                    if (bad) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display({"mismatch item %0d: exp dir %0d %0d %0d move %0d %0d,",
                                " got dir %0d %0d %0d move %0d %0d"},
                                n_results, e.dir_x, e.dir_y, e.dir_z, e.move_x, e.move_z,
                                m_dir_x, m_dir_y, m_dir_z, m_move_x, m_move_z);
                    end
                end
            end
            if ($urandom_range(0, 199) == 0) m_burst = !m_burst;
            if (hold_cnt > 0) begin
                m_ready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                m_gap = pick_gap(m_burst);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_SENSITIVITY) sens_reg = val & 32'h3FF;
        else if (idx == CFG_MAX_PITCH) maxp_reg = val & 32'h7F;
    endtask

    task automatic add_frame(input int dx, input int dy, input int ft, input logic [3:0] keys);
        frame_in_t f;
        f.dx = dx[15:0]; f.dy = dy[15:0]; f.ft = ft[15:0];
        {f.kf, f.kb, f.kl, f.kr} = keys;
        pending_frames.push_back(f);
    endtask

    // Mostly modest mouse motion and frame times, some full-range noise
    task automatic add_random_frames(input int count);
        int dx, dy, ft;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 3))
                0: begin
                    dx = $urandom_range(0, 65535); dy = $urandom_range(0, 65535);
                    ft = $urandom_range(0, 65535);
                end
                1: begin
                    dx = $urandom_range(0, 400) - 200; dy = $urandom_range(0, 400) - 200;
                    ft = $urandom_range(0, 65535);
                end
                default: begin
                    dx = $urandom_range(0, 40) - 20; dy = $urandom_range(0, 40) - 20;
                    ft = $urandom_range(0, 2000);
                end
            endcase
            add_frame(dx, dy, ft, 4'($urandom_range(0, 15)));
        end
    endtask

    task automatic drain;
        do @(posedge aclk);
        while (pending_frames.size() != 0 || s_valid || expected_vecs.size() != 0);
    endtask

    initial begin
        yaw_deg = 0; pitch_deg = 0;
        sens_reg = SENS_RESET; maxp_reg = MAXP_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset settings, field extremes, every key combination
        add_frame(0, 0, 0, 4'b0000);
        add_frame(32767, 0, 65535, 4'b1000);
        add_frame(-32768, 0, 65535, 4'b0100);
        add_frame(0, 32767, 65535, 4'b0010);
        add_frame(0, -32768, 65535, 4'b0001);
        add_frame(-32768, -32768, 65535, 4'b1111);
        add_frame(32767, 32767, 0, 4'b1100);
        add_frame(1, -1, 1, 4'b0011);
        for (int k = 0; k < 16; k++) add_frame(k * 37 - 200, k * 11 - 80, 4096, 4'(k));
        drain();

        // Large limit acts as the cap; top sensitivity
        write_reg(CFG_SENSITIVITY, 1023);
        write_reg(CFG_MAX_PITCH, 127);
        add_frame(0, -32768, 65535, 4'b1010);
        add_random_frames(200);
        drain();

        // Pitch parked near the top, then the limit drops
        write_reg(CFG_MAX_PITCH, 89);
        add_frame(0, -30000, 65535, 4'b0000);
        drain();
        write_reg(CFG_MAX_PITCH, 10);
        write_reg(2, 1023);
        write_reg(3, 0);
        add_frame(0, 0, 0, 4'b0101);
        hold_go = 1'b1;
        add_random_frames(200);
        drain();

        // Zero sensitivity and zero pitch limit
        write_reg(CFG_SENSITIVITY, 0);
        write_reg(CFG_MAX_PITCH, 0);
        add_random_frames(150);
        drain();

        write_reg(CFG_SENSITIVITY, 1);
        write_reg(CFG_MAX_PITCH, 45);
        add_random_frames(200);
        drain();

        write_reg(CFG_SENSITIVITY, $urandom_range(0, 1023));
        write_reg(CFG_MAX_PITCH, $urandom_range(0, 127));
        add_random_frames(150);
        drain();

        write_reg(CFG_SENSITIVITY, 100);
        write_reg(CFG_MAX_PITCH, 89);
        add_random_frames(180);
        drain();

        repeat (200) @(posedge aclk);
        $display("covered %0d frame items over eight register settings, %0d results checked",
            n_accepted, n_results);
        $display("settings included zero/full sensitivity, zero/capped/lowered pitch limit");
        if (n_errors == 0 && expected_vecs.size() == 0)
            $display("yaw_pitch_camera_vector_unit regression: pass");
        else
            $display("yaw_pitch_camera_vector_unit regression: fail");
        $finish;
    end

    initial begin
        #40ms;
        $display("timeout");
        $display("yaw_pitch_camera_vector_unit regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
hdl/ypcv_pkg.sv
hdl/ypcv_cordic.sv
hdl/yaw_pitch_camera_vector_unit.sv
hdl/ypcv_checker.sv
tb/yaw_pitch_camera_vector_unit_tb.sv
